/* rtl/cbts_pkg.sv */
// Shared types and constants for the CAN bit-timing search block.
// Used by cbts_div, cbts_seq and can_bit_timing_search.
package cbts_pkg;

  localparam int CLK_W    = 32;
  localparam int RATE_W   = 24;
  localparam int SAMP_W   = 16;
  localparam int T1_W     = 9;
  localparam int T2_W     = 8;
  localparam int BRP_W    = 11;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 11;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 48;

  localparam logic [IDX_W-1:0] REG_T1_MIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_T1_MAX  = 3'd1;
  localparam logic [IDX_W-1:0] REG_T2_MIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_T2_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SJW     = 3'd4;
  localparam logic [IDX_W-1:0] REG_BRP_MIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_BRP_MAX = 3'd6;
  localparam logic [IDX_W-1:0] REG_BRP_STP = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_BRP, S_MUL, S_DIVGO, S_DIVW, S_CHK, S_T2, S_ERR, S_CMP, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [55:0] dividend;
    logic [34:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [55:0] quot;
    logic        rem_zero;
  } div_rsp_t;

endpackage

/* rtl/cbts_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cbts_pkg.
module cbts_div
  import cbts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [55:0] quot;
  logic [35:0] rem;
  logic [34:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] trial;
  logic [35:0] diff;

  assign trial = {rem[34:0], quot[55]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd56;
      quot <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      if (diff[35]) begin
        rem  <= trial;
        quot <= {quot[54:0], 1'b0};
      end else begin
        rem  <= diff;
        quot <= {quot[54:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign rsp.busy     = busy | req.start;
  assign rsp.quot     = quot;
  assign rsp.rem_zero = (rem == '0);

endmodule

/* rtl/cbts_seq.sv */
// Search sequencer: walks prescalers and tseg2 values, keeps the best split.
// Depends on cbts_pkg and drives the shared divider cbts_div.
module cbts_seq
  import cbts_pkg::*;
#(
  parameter int MAX_PRESCALER    = 1024,
  parameter int MAX_TSEG1        = 256,
  parameter int MAX_TSEG2        = 128,
  parameter int SAMPLE_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  clock_hz,
  input  logic [RATE_W-1:0] bit_rate,
  input  logic [SAMP_W-1:0] sample_target,
  input  logic [T1_W-1:0]   t1_min_r,
  input  logic [T1_W-1:0]   t1_max_r,
  input  logic [T2_W-1:0]   t2_min_r,
  input  logic [T2_W-1:0]   t2_max_r,
  input  logic [T2_W-1:0]   sjw_r,
  input  logic [BRP_W-1:0]  brp_min_r,
  input  logic [BRP_W-1:0]  brp_max_r,
  input  logic [BRP_W-1:0]  brp_step_r,
  output div_req_t          dreq,
  input  div_rsp_t          drsp,
  output logic              busy,
  output logic              done,
  output logic [OUT_W-1:0]  result
);

  localparam logic [BRP_W:0] PMAX = (BRP_W+1)'(MAX_PRESCALER > 2047 ? 2047 : MAX_PRESCALER);
  localparam logic [T1_W:0]  T1M  = (T1_W+1)'(MAX_TSEG1 > 511 ? 511 : MAX_TSEG1);
  localparam logic [T2_W:0]  T2M  = (T2_W+1)'(MAX_TSEG2 > 255 ? 255 : MAX_TSEG2);

  state_t state, state_next;

  logic [CLK_W-1:0]  clk_q;
  logic [RATE_W-1:0] rate_q;
  logic [SAMP_W-1:0] tgt_q;
  logic [BRP_W:0]    brp, phi;
  logic [T1_W:0]     t1lo, t1hi;
  logic [T2_W:0]     t2lo, t2hi, t2;
  logic [34:0]       denom;
  logic [CLK_W-1:0]  tq;
  logic [CLK_W-1:0]  seg;
  logic [CLK_W-1:0]  t1;
  // error numerator stays below 2^34; tq of a candidate stays below 1024
  logic [33:0]       num, best_num;
  logic [9:0]        best_tq;
  logic [43:0]       lhs, rhs;
  logic              found;
  logic [BRP_W-1:0]  best_brp;
  logic [T1_W-1:0]   best_t1;
  logic [T2_W-1:0]   best_t2;
  logic [BRP_W-1:0]  step;
  logic [47:0]       a_v, b_v;
  logic [T1_W-1:0]   prop;
  logic [T2_W-1:0]   sjw_o;

  assign step = (brp_step_r == '0) ? BRP_W'(1) : brp_step_r;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = (clock_hz == '0 || bit_rate == '0) ? S_DONE : S_BRP;
      S_BRP:   state_next = (brp > phi) ? S_DONE : (brp == '0 ? S_BRP : S_MUL);
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIVW;
      S_DIVW:  if (!drsp.busy) state_next = S_CHK;
      S_CHK:   state_next = (!drsp.rem_zero || tq < 32'd3 ||
                             {1'b0, tq - 32'd1} > 33'(t1hi) + 33'(t2hi)) ? S_BRP : S_T2;
      S_T2:    state_next = (t2 > t2hi || 32'(t2) >= seg) ? S_BRP : S_ERR;
      S_ERR:   state_next = S_CMP;
      S_CMP:   state_next = S_T2;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign a_v = 48'(33'(t1) + 33'd1) << SAMPLE_FRAC_BITS;
  assign b_v = 48'(tgt_q) * 48'(tq);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        clk_q  <= clock_hz;
        rate_q <= bit_rate;
        tgt_q  <= sample_target;
        found  <= 1'b0;
        best_num <= '0;
        best_tq  <= 10'd1;
        t1lo <= ({1'b0, t1_min_r} > T1M) ? T1M : {1'b0, t1_min_r};
        t1hi <= ({1'b0, t1_max_r} > T1M) ? T1M : {1'b0, t1_max_r};
        t2lo <= ({1'b0, t2_min_r} > T2M) ? T2M : {1'b0, t2_min_r};
        t2hi <= ({1'b0, t2_max_r} > T2M) ? T2M : {1'b0, t2_max_r};
        brp  <= ({1'b0, brp_min_r} > PMAX) ? PMAX : {1'b0, brp_min_r};
        phi  <= ({1'b0, brp_max_r} > PMAX) ? PMAX : {1'b0, brp_max_r};
      end
      S_BRP: if (brp == '0 && brp <= phi) brp <= brp + (BRP_W+1)'(step);
      S_MUL: denom <= 35'(brp) * 35'(rate_q);
      S_CHK: begin
        seg <= tq - 32'd1;
        t2  <= t2lo;
        if (!(drsp.rem_zero && tq >= 32'd3 &&
              {1'b0, tq - 32'd1} <= 33'(t1hi) + 33'(t2hi)))
          brp <= brp + (BRP_W+1)'(step);
      end
      S_T2: begin
        t1 <= seg - 32'(t2);
        if (t2 > t2hi || 32'(t2) >= seg) brp <= brp + (BRP_W+1)'(step);
      end
      S_ERR: begin
        num <= (t1 < 32'(t1lo) || t1 > 32'(t1hi)) ? '1 :
               34'((a_v > b_v) ? a_v - b_v : b_v - a_v);
      end
      S_CMP: begin
        // out-of-range tseg1 marked with all-ones num and skipped
        if (!(t1 < 32'(t1lo) || t1 > 32'(t1hi)) && (!found || lhs < rhs)) begin
          found    <= 1'b1;
          best_num <= num;
          best_tq  <= tq[9:0];
          best_brp <= brp[BRP_W-1:0];
          best_t1  <= t1[T1_W-1:0];
          best_t2  <= t2[T2_W-1:0];
        end
        t2 <= t2 + (T2_W+1)'(1);
      end
      default: ;
    endcase
  end

  assign tq = drsp.quot[CLK_W-1:0];
  assign lhs = num * best_tq;
  assign rhs = best_num * tq[9:0];

  assign dreq.start    = (state == S_DIVGO);
  assign dreq.dividend = 56'(clk_q);
  assign dreq.divisor  = denom;

  assign prop  = best_t1 >> 1;
  assign sjw_o = (sjw_r < best_t2) ? sjw_r : best_t2;
  assign busy  = (state != S_IDLE);
  assign done  = (state == S_DONE);
  assign result = found ? {4'b0, best_brp, sjw_o, best_t2,
                           8'(best_t1 - prop), 8'(prop), 1'b1} : '0;

endmodule

/* rtl/can_bit_timing_search.sv */
// CAN bit-timing search, top level: config registers, output register.
// Depends on cbts_pkg, cbts_div and cbts_seq.
//
// Usage:
//   s_axis carries one request word: clock_hz, bit_rate, sample_target.
//   m_axis carries one result word per request.
//   Config writes (cfg_we/cfg_index/cfg_data) only while idle.
// Each prescaler in range runs one 56-step divide in the shared divider;
// one that gives an exact quanta count within limits then tries the tseg2
// values in turn. A zero prescaler is skipped without a divide.
// Zero clock or rate: no search is run; the sequencer goes straight to S_DONE.
// One request is in flight at a time; s_axis_tready is low while searching
// and while the result word waits in the output register.
// If the receiver stalls, the result holds in m_axis_tdata until taken.
// Reset returns the config registers to their defaults and drops any
// request in progress.
module can_bit_timing_search
  import cbts_pkg::*;
#(
  parameter int MAX_PRESCALER    = 1024,
  parameter int MAX_TSEG1        = 256,
  parameter int MAX_TSEG2        = 128,
  parameter int SAMPLE_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // clock_hz[31:0], bit_rate[55:32], sample_target[71:56]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // found[0], prop_segment[8:1], phase_segment1[16:9], phase_segment2[24:17],
  // jump_width[32:25], prescaler[43:33]
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [T1_W-1:0]  t1_min, t1_max;
  logic [T2_W-1:0]  t2_min, t2_max, sjw;
  logic [BRP_W-1:0] brp_min, brp_max, brp_step;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic             busy, done, start;
  logic [OUT_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_min <= 9'd1; t1_max <= 9'd16; t2_min <= 8'd1; t2_max <= 8'd8;
      sjw <= 8'd4; brp_min <= 11'd1; brp_max <= 11'd1024; brp_step <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_T1_MIN:  t1_min   <= cfg_data[T1_W-1:0];
        REG_T1_MAX:  t1_max   <= cfg_data[T1_W-1:0];
        REG_T2_MIN:  t2_min   <= cfg_data[T2_W-1:0];
        REG_T2_MAX:  t2_max   <= cfg_data[T2_W-1:0];
        REG_SJW:     sjw      <= cfg_data[T2_W-1:0];
        REG_BRP_MIN: brp_min  <= cfg_data;
        REG_BRP_MAX: brp_max  <= cfg_data;
        REG_BRP_STP: brp_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;

  cbts_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  cbts_seq #(
    .MAX_PRESCALER(MAX_PRESCALER), .MAX_TSEG1(MAX_TSEG1),
    .MAX_TSEG2(MAX_TSEG2), .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) u_seq (
    .clk(clk), .rst(rst), .start(start),
    .clock_hz(s_axis_tdata[31:0]), .bit_rate(s_axis_tdata[55:32]),
    .sample_target(s_axis_tdata[71:56]),
    .t1_min_r(t1_min), .t1_max_r(t1_max), .t2_min_r(t2_min), .t2_max_r(t2_max),
    .sjw_r(sjw), .brp_min_r(brp_min), .brp_max_r(brp_max), .brp_step_r(brp_step),
    .dreq(dreq), .drsp(drsp), .busy(busy), .done(done), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) m_axis_tdata <= result;
  end

endmodule
